// File: design/bpa_pkg.sv
// Shared types and codes for the buddy page allocator.
`default_nettype none

package bpa_pkg;

   localparam int ORDER_W  = 4;
   localparam int PAGE_W   = 12;
   localparam int STATUS_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_SEARCH,
      S_UN_RD,
      S_UN_WR,
      S_UP_RD,
      S_UP_WR,
      S_UN_NX_RD,
      S_UN_NX_WR,
      S_SPLIT,
      S_AP_RD,
      S_AP_WR,
      S_AT_RD,
      S_AT_WR,
      S_FIN_RD,
      S_FIN_WR,
      S_FR_RD,
      S_FR_WR,
      S_MERGE,
      S_MCHK,
      S_MNEXT,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// File: design/bpa_if.sv
// Request and response channel interfaces of the buddy page allocator.
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [ORDER_W-1:0] block_order;
   logic [PAGE_W-1:0]  page_index;

   modport source (output valid, operation, block_order, page_index, input ready);
   modport sink   (input valid, operation, block_order, page_index, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PAGE_W-1:0]   block_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, block_index, status, input ready);
   modport sink   (input valid, block_index, status, output ready);
endinterface

`default_nettype wire

// File: design/bpa_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
`default_nettype none

module bpa_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: design/buddy_page_allocator.sv
// Buddy page allocator: per-order FIFO free lists kept in one page RAM.
// Allocate: unlink the lowest free order's head, append split halves, mark it in use.
// Free: clear in_use, merge with each listed buddy of equal order, append the result.
// Each RAM update after the clear is a read, then a write next cycle; one item at a time.
// The result sits in an output register, so the next request is taken while it waits.
// After reset a clearing pass writes all PAGE_COUNT entries.
`default_nettype none

module buddy_page_allocator import bpa_pkg::*; #(
   parameter int TOP_ORDER  = 10,
   parameter int PAGE_COUNT = 4096
) (
   input wire logic  clock,
   input wire logic  reset,
   bpa_req_if.sink   req_if,
   bpa_rsp_if.source rsp_if
);

   localparam int IW = $clog2(PAGE_COUNT);
   localparam int LW = $clog2(PAGE_COUNT + 1);
   localparam int OW = $clog2(TOP_ORDER + 1);
   localparam int KW = $clog2(TOP_ORDER + 2);
   localparam int CW = ((LW > TOP_ORDER) ? LW : TOP_ORDER) + 2;
   localparam int NUM_TOP = PAGE_COUNT >> TOP_ORDER;
   localparam logic [LW-1:0] NONE = LW'(PAGE_COUNT);
   localparam logic [CW-1:0] TOP_SZ = CW'(1) << TOP_ORDER;
   localparam logic [CW-1:0] PC_W = CW'(PAGE_COUNT);
   localparam logic [LW-1:0] TOP_HEAD_RST = (NUM_TOP > 0) ? LW'(0) : NONE;
   localparam logic [LW-1:0] TOP_TAIL_RST =
      (NUM_TOP > 0) ? LW'((NUM_TOP - 1) << TOP_ORDER) : NONE;

   typedef struct packed {
      logic [OW-1:0] order;
      logic          in_use;
      logic          listed;
      logic [LW-1:0] next;
      logic [LW-1:0] prev;
   } entry_type;

   localparam int WW = $bits(entry_type);

   state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] want_ff, want_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] u_ff, u_in;
   logic [IW-1:0] b_ff, b_in;
   logic [IW-1:0] ap_ff, ap_in;
   logic [IW-1:0] t_ff, t_in;
   logic [LW-1:0] pr_ff, pr_in;
   logic [LW-1:0] nx_ff, nx_in;
   logic          op_ff, op_in;
   logic [PAGE_W-1:0]   res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [LW-1:0] head_ff [TOP_ORDER+1];
   logic [LW-1:0] head_in [TOP_ORDER+1];
   logic [LW-1:0] tail_ff [TOP_ORDER+1];
   logic [LW-1:0] tail_in [TOP_ORDER+1];

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [IW-1:0] mem_raddr;
   entry_type     mem_wdata;
   logic [WW-1:0] mem_rbits;
   entry_type     mem_q;

   logic [CW-1:0] ci;
   logic          clr_top;
   logic [CW-1:0] bw;
   logic [OW-1:0] kidx;
   logic [KW-1:0] kclamp;
   state_type     ret_un;
   state_type     ret_ap;

   bpa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(WW)) u_bpa_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rbits)
   );

   assign mem_q = entry_type'(mem_rbits);
   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.block_index = rsp_idx_ff;
   assign rsp_if.status = rsp_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= TOP_ORDER; i++) begin
            head_ff[i] <= (i == TOP_ORDER) ? TOP_HEAD_RST : NONE;
            tail_ff[i] <= (i == TOP_ORDER) ? TOP_TAIL_RST : NONE;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
      k_ff <= k_in;
      want_ff <= want_in;
      p_ff <= p_in;
      u_ff <= u_in;
      b_ff <= b_in;
      ap_ff <= ap_in;
      t_ff <= t_in;
      pr_ff <= pr_in;
      nx_ff <= nx_in;
      op_ff <= op_in;
      res_idx_ff <= res_idx_in;
      res_st_ff <= res_st_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_st_ff <= rsp_st_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      want_in = want_ff;
      p_in = p_ff;
      u_in = u_ff;
      b_in = b_ff;
      ap_in = ap_ff;
      t_in = t_ff;
      pr_in = pr_ff;
      nx_in = nx_ff;
      op_in = op_ff;
      res_idx_in = res_idx_ff;
      res_st_in = res_st_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_st_in = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      head_in = head_ff;
      tail_in = tail_ff;
      mem_we = 1'b0;
      mem_waddr = u_ff;
      mem_raddr = u_ff;
      mem_wdata = mem_q;

      kidx = k_ff[OW-1:0];
      kclamp = (mem_q.order > OW'(TOP_ORDER)) ? KW'(TOP_ORDER) : KW'(mem_q.order);
      bw = CW'(p_ff) ^ (CW'(1) << k_ff);
      ret_un = (op_ff == OP_FREE) ? S_MNEXT : S_SPLIT;
      ret_ap = (op_ff == OP_FREE) ? S_DONE : S_SPLIT;

      ci = CW'(cnt_ff);
      clr_top = (ci[TOP_ORDER-1:0] == '0) && (ci + TOP_SZ <= PC_W);

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata.order = clr_top ? OW'(TOP_ORDER) : '0;
            mem_wdata.in_use = 1'b0;
            mem_wdata.listed = clr_top;
            mem_wdata.next = (clr_top && (ci + (TOP_SZ << 1) <= PC_W)) ?
                             LW'(ci + TOP_SZ) : NONE;
            mem_wdata.prev = (clr_top && (ci >= TOP_SZ)) ? LW'(ci - TOP_SZ) : NONE;
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == IW'(PAGE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               op_in = req_if.operation;
               if (req_if.operation == OP_ALLOC) begin
                  if (CW'(req_if.block_order) > CW'(TOP_ORDER)) begin
                     res_idx_in = '0;
                     res_st_in = ST_NO_MEMORY;
                     state_in = S_DONE;
                  end else begin
                     want_in = KW'(req_if.block_order);
                     k_in = KW'(req_if.block_order);
                     state_in = S_SEARCH;
                  end
               end else begin
                  if (CW'(req_if.page_index) >= PC_W) begin
                     res_idx_in = '0;
                     res_st_in = ST_BAD_FREE;
                     state_in = S_DONE;
                  end else begin
                     p_in = IW'(req_if.page_index);
                     state_in = S_FR_RD;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (k_ff > KW'(TOP_ORDER)) begin
               res_idx_in = '0;
               res_st_in = ST_NO_MEMORY;
               state_in = S_DONE;
            end else if (head_ff[kidx] == NONE) begin
               k_in = k_ff + KW'(1);
            end else begin
               p_in = head_ff[kidx][IW-1:0];
               u_in = head_ff[kidx][IW-1:0];
               state_in = S_UN_RD;
            end
         end
         S_UN_RD: begin
            mem_raddr = u_ff;
            state_in = S_UN_WR;
         end
         S_UN_WR: begin
            pr_in = mem_q.prev;
            nx_in = mem_q.next;
            mem_we = 1'b1;
            mem_waddr = u_ff;
            mem_wdata.prev = NONE;
            mem_wdata.next = NONE;
            mem_wdata.listed = 1'b0;
            if (mem_q.prev == NONE) begin
               head_in[kidx] = mem_q.next;
            end
            if (mem_q.next == NONE) begin
               tail_in[kidx] = mem_q.prev;
            end
            if (mem_q.prev != NONE) begin
               state_in = S_UP_RD;
            end else if (mem_q.next != NONE) begin
               state_in = S_UN_NX_RD;
            end else begin
               state_in = ret_un;
            end
         end
         S_UP_RD: begin
            mem_raddr = pr_ff[IW-1:0];
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            mem_we = 1'b1;
            mem_waddr = pr_ff[IW-1:0];
            mem_wdata.next = nx_ff;
            state_in = (nx_ff != NONE) ? S_UN_NX_RD : ret_un;
         end
         S_UN_NX_RD: begin
            mem_raddr = nx_ff[IW-1:0];
            state_in = S_UN_NX_WR;
         end
         S_UN_NX_WR: begin
            mem_we = 1'b1;
            mem_waddr = nx_ff[IW-1:0];
            mem_wdata.prev = pr_ff;
            state_in = ret_un;
         end
         S_SPLIT: begin
            if (k_ff > want_ff) begin
               k_in = k_ff - KW'(1);
               ap_in = p_ff ^ (IW'(1) << (k_ff - KW'(1)));
               state_in = S_AP_RD;
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_AP_RD: begin
            mem_raddr = ap_ff;
            state_in = S_AP_WR;
         end
         S_AP_WR: begin
            mem_we = 1'b1;
            mem_waddr = ap_ff;
            mem_wdata.prev = tail_ff[kidx];
            mem_wdata.next = NONE;
            mem_wdata.listed = 1'b1;
            mem_wdata.order = kidx;
            tail_in[kidx] = LW'(ap_ff);
            t_in = tail_ff[kidx][IW-1:0];
            if (tail_ff[kidx] == NONE) begin
               head_in[kidx] = LW'(ap_ff);
               state_in = ret_ap;
            end else begin
               state_in = S_AT_RD;
            end
         end
         S_AT_RD: begin
            mem_raddr = t_ff;
            state_in = S_AT_WR;
         end
         S_AT_WR: begin
            mem_we = 1'b1;
            mem_waddr = t_ff;
            mem_wdata.next = LW'(ap_ff);
            state_in = ret_ap;
         end
         S_FIN_RD: begin
            mem_raddr = p_ff;
            state_in = S_FIN_WR;
         end
         S_FIN_WR: begin
            mem_we = 1'b1;
            mem_waddr = p_ff;
            mem_wdata.order = want_ff[OW-1:0];
            mem_wdata.in_use = 1'b1;
            res_idx_in = PAGE_W'(p_ff);
            res_st_in = ST_ALLOCATED;
            state_in = S_DONE;
         end
         S_FR_RD: begin
            mem_raddr = p_ff;
            state_in = S_FR_WR;
         end
         S_FR_WR: begin
            if (!mem_q.in_use) begin
               res_idx_in = '0;
               res_st_in = ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               mem_we = 1'b1;
               mem_waddr = p_ff;
               mem_wdata.in_use = 1'b0;
               k_in = kclamp;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            res_idx_in = '0;
            res_st_in = ST_FREED;
            if ((k_ff >= KW'(TOP_ORDER)) || (bw >= PC_W)) begin
               ap_in = p_ff;
               state_in = S_AP_RD;
            end else begin
               b_in = bw[IW-1:0];
               mem_raddr = bw[IW-1:0];
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (mem_q.listed && (KW'(mem_q.order) == k_ff)) begin
               u_in = b_ff;
               state_in = S_UN_RD;
            end else begin
               ap_in = p_ff;
               state_in = S_AP_RD;
            end
         end
         S_MNEXT: begin
            if (b_ff < p_ff) begin
               p_in = b_ff;
            end
            k_in = k_ff + KW'(1);
            state_in = S_MERGE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in = res_idx_ff;
               rsp_st_in = res_st_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/bpa_checker.sv
// Port-level checks of the buddy page allocator and their bind.
`default_nettype none

module bpa_checker import bpa_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [PAGE_W-1:0]   rsp_block_index,
   input wire logic [STATUS_W-1:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_block_index))
      else $error("Response changed while stalled.");

   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_ALLOCATED) |-> rsp_block_index == '0)
      else $error("Nonzero block index without an allocation.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken while another is in flight.");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("Request ready before the clearing pass.");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("Response appeared without a request in flight.");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_block_index (rsp_if.block_index),
   .rsp_status      (rsp_if.status)
);

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the buddy page allocator with a behavioral allocator predictor.
`timescale 1ns / 100ps

module tb import bpa_pkg::*; ();

   localparam int TOP = 10;
   localparam int PAGES = 4096;
   localparam int NIL = PAGES;

   typedef struct packed {
      logic               operation;
      logic [ORDER_W-1:0] block_order;
      logic [PAGE_W-1:0]  page_index;
   } request_type;

   typedef struct packed {
      logic [PAGE_W-1:0]   block_index;
      logic [STATUS_W-1:0] status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpa_req_if req_if ();
   bpa_rsp_if rsp_if ();

   buddy_page_allocator DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   int        blk_order[PAGES];
   bit        blk_used[PAGES];
   bit        blk_listed[PAGES];
   int        link_next[PAGES];
   int        link_prev[PAGES];
   int        order_first[TOP + 1];
   int        order_last[TOP + 1];

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int        live_blocks[$];
   int        errors = 0;
   bit        stimulus_done = 1'b0;
   int        send_gap = 0;
   int        hold_gap = 0;
   int        accept_count = 0;
   int        drop_count = 0;

   function automatic int pick_gap();
      int r;
      begin
         r = $urandom_range(0, 99);
         if (r < 45) pick_gap = 0;
         else if (r < 90) pick_gap = $urandom_range(1, 3);
         else pick_gap = $urandom_range(10, 40);
      end
   endfunction

   function automatic void free_list_push(int k, int p);
      int t;
      begin
         t = order_last[k];
         link_prev[p] = t;
         link_next[p] = NIL;
         if (t == NIL) order_first[k] = p;
         else link_next[t] = p;
         order_last[k] = p;
         blk_listed[p] = 1'b1;
      end
   endfunction

   function automatic void free_list_remove(int k, int p);
      int pr;
      int nx;
      begin
         pr = link_prev[p];
         nx = link_next[p];
         if (pr == NIL) order_first[k] = nx;
         else link_next[pr] = nx;
         if (nx == NIL) order_last[k] = pr;
         else link_prev[nx] = pr;
         link_prev[p] = NIL;
         link_next[p] = NIL;
         blk_listed[p] = 1'b0;
      end
   endfunction

   function automatic void allocator_reset();
      begin
         for (int i = 0; i < PAGES; i++) begin
            blk_order[i] = 0;
            blk_used[i] = 1'b0;
            blk_listed[i] = 1'b0;
            link_next[i] = NIL;
            link_prev[i] = NIL;
         end
         for (int k = 0; k <= TOP; k++) begin
            order_first[k] = NIL;
            order_last[k] = NIL;
         end
         for (int i = 0; i + (1 << TOP) <= PAGES; i += (1 << TOP)) begin
            blk_order[i] = TOP;
            free_list_push(TOP, i);
         end
      end
   endfunction

   function automatic answer_type allocator_step(request_type rq);
      answer_type a;
      int k;
      int p;
      int b;
      int want;
      begin
         a.block_index = '0;
         want = rq.block_order;
         if (rq.operation == OP_ALLOC) begin
            a.status = ST_NO_MEMORY;
            if (want <= TOP) begin
               k = want;
               while (k <= TOP && order_first[k] == NIL) k++;
               if (k <= TOP) begin
                  p = order_first[k];
                  free_list_remove(k, p);
                  while (k > want) begin
                     k--;
                     b = p ^ (1 << k);
                     blk_order[b] = k;
                     free_list_push(k, b);
                  end
                  blk_order[p] = want;
                  blk_used[p] = 1'b1;
                  a.block_index = PAGE_W'(p);
                  a.status = ST_ALLOCATED;
               end
            end
         end else begin
            p = rq.page_index;
            if (!blk_used[p]) begin
               a.status = ST_BAD_FREE;
            end else begin
               k = blk_order[p];
               if (k > TOP) k = TOP;
               blk_used[p] = 1'b0;
               while (k < TOP) begin
                  b = p ^ (1 << k);
                  if (b >= PAGES || !blk_listed[b] || blk_order[b] != k) break;
                  free_list_remove(k, b);
                  if (b < p) p = b;
                  k++;
               end
               blk_order[p] = k;
               free_list_push(k, p);
               a.status = ST_FREED;
            end
         end
         allocator_step = a;
      end
   endfunction

   // The stimulus shadow tracks allocated heads so that most frees are valid.
   task automatic queue_request(logic op, int ord, int page);
      request_type rq;
      begin
         rq.operation = op;
         rq.block_order = ord[ORDER_W-1:0];
         rq.page_index = page[PAGE_W-1:0];
         pending_requests = {pending_requests, rq};
      end
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      bit taken;
      taken = 1'b0;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.operation <= OP_ALLOC;
         req_if.block_order <= '0;
         req_if.page_index <= '0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (accept_count != drop_count) begin
            pending_requests.delete(0);
            drop_count++;
            send_gap = pick_gap();
            taken = 1'b1;
         end
         if (taken || !req_if.valid) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.operation <= pending_requests[0].operation;
               req_if.block_order <= pending_requests[0].block_order;
               req_if.page_index <= pending_requests[0].page_index;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            hold_gap = pick_gap();
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      request_type rq;
      answer_type got;
      answer_type exp_ans;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            rq.operation = req_if.operation;
            rq.block_order = req_if.block_order;
            rq.page_index = req_if.page_index;
            expected_answers = {expected_answers, allocator_step(rq)};
            accept_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.block_index = rsp_if.block_index;
            got.status = rsp_if.status;
            if (expected_answers.size() == 0) begin
               $error("unexpected transfer: block_index %0d status %0d",
                      got.block_index, got.status);
               errors++;
            end else begin
               exp_ans = expected_answers[0];
               expected_answers.delete(0);
               if (got.block_index !== exp_ans.block_index) begin
                  $error("block_index expected %0d actual %0d",
                         exp_ans.block_index, got.block_index);
                  errors++;
               end
               if (got.status !== exp_ans.status) begin
                  $error("status expected %0d actual %0d", exp_ans.status, got.status);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int mode;
      int ord;
      int idx;
      int pg;
      allocator_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      queue_request(OP_FREE, 0, 0);
      queue_request(OP_ALLOC, 15, 0);
      queue_request(OP_ALLOC, 11, 4095);
      queue_request(OP_ALLOC, 0, 4095);
      queue_request(OP_FREE, 0, 0);
      queue_request(OP_FREE, 15, 0);
      for (int i = 0; i < 4; i++) queue_request(OP_ALLOC, 10, 0);
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_ALLOC, 10, 0);
      queue_request(OP_FREE, 0, 4095);
      queue_request(OP_FREE, 0, 2048);
      queue_request(OP_FREE, 0, 1024);
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_ALLOC, 3, 0);
      queue_request(OP_FREE, 0, 1);
      queue_request(OP_FREE, 0, 0);
      queue_request(OP_FREE, 0, 0);
      queue_request(OP_FREE, 0, 8);
      queue_request(OP_FREE, 0, 3072);
      queue_request(OP_FREE, 0, 1023);

      // Track heads handed out by a second predictor copy is unnecessary:
      // valid frees come from heads seen in earlier allocation responses, steered in at send time.
      for (int i = 0; i < 930; i++) begin
         mode = $urandom_range(0, 99);
         if (mode < 50) begin
            ord = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 15);
            queue_request(OP_ALLOC, ord, $urandom_range(0, 4095));
         end else if (mode < 90) begin
            pg = $urandom_range(0, 4095);
            if (mode < 80) pg = pg & ~($urandom_range(0, 63));
            queue_request(OP_FREE, $urandom_range(0, 15), pg);
         end else begin
            queue_request(OP_FREE, $urandom_range(0, 15), $urandom_range(0, 4095));
         end
      end
      stimulus_done = 1'b1;
   end

   // Random frees above mostly miss; steer them to live heads at send time.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready && rsp_if.status == ST_ALLOCATED)
         live_blocks = {live_blocks, int'(rsp_if.block_index)};
   end

   always @(negedge clock) begin
      int j;
      if (!reset && pending_requests.size() > 1 && live_blocks.size() > 0
          && pending_requests[1].operation == OP_FREE && $urandom_range(0, 9) < 8) begin
         j = $urandom_range(0, live_blocks.size() - 1);
         pending_requests[1].page_index = PAGE_W'(live_blocks[j]);
         live_blocks.delete(j);
      end
   end

   initial begin
      wait (stimulus_done);
      while (pending_requests.size() > 0 || expected_answers.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #60ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
design/bpa_pkg.sv
design/bpa_if.sv
design/bpa_ram.sv
design/buddy_page_allocator.sv
design/bpa_checker.sv
verif/tb.sv
